>>> rtl/core/tlseq_pkg.sv
// types, constants and phase tables for the two-road traffic light sequencer
`default_nettype none

package tlseq_pkg;

  localparam int NUM_DUR = 6;
  localparam int CFG_W = 8;
  localparam int IDX_W = 3;

  typedef enum logic [1:0] {
    PH_RED    = 2'd0,
    PH_GREEN  = 2'd1,
    PH_YELLOW = 2'd2,
    PH_UPDATE = 2'd3
  } phase_t;

  typedef enum logic {
    ROAD_A = 1'b0,
    ROAD_B = 1'b1
  } road_t;

  // duration, register and lamp index
  localparam logic [IDX_W-1:0] IDX_RED_A    = 3'd0;
  localparam logic [IDX_W-1:0] IDX_GREEN_A  = 3'd1;
  localparam logic [IDX_W-1:0] IDX_YELLOW_A = 3'd2;
  localparam logic [IDX_W-1:0] IDX_RED_B    = 3'd3;
  localparam logic [IDX_W-1:0] IDX_GREEN_B  = 3'd4;
  localparam logic [IDX_W-1:0] IDX_YELLOW_B = 3'd5;
  localparam logic [IDX_W-1:0] IDX_NONE     = 3'd6;

  localparam logic [NUM_DUR-1:0][CFG_W-1:0] RESET_DUR = {
    8'd2, 8'd3, 8'd5, 8'd2, 8'd3, 8'd5
  };

  typedef struct packed {
    logic               pending;
    logic [NUM_DUR-1:0] lamps;
  } pass_ctl_t;

  function automatic phase_t road_next_phase(road_t road, phase_t ph);
    phase_t nxt;
    if (road == ROAD_A) begin
      unique case (ph)
        PH_RED:    nxt = PH_GREEN;
        PH_GREEN:  nxt = PH_YELLOW;
        PH_YELLOW: nxt = PH_UPDATE;
        PH_UPDATE: nxt = PH_RED;
        default:   nxt = PH_RED;
      endcase
    end else begin
      unique case (ph)
        PH_RED:    nxt = PH_UPDATE;
        PH_GREEN:  nxt = PH_YELLOW;
        PH_YELLOW: nxt = PH_RED;
        PH_UPDATE: nxt = PH_GREEN;
        default:   nxt = PH_GREEN;
      endcase
    end
    return nxt;
  endfunction

  // duration loaded on leaving a phase
  function automatic logic [IDX_W-1:0] road_load_idx(road_t road, phase_t ph);
    logic [IDX_W-1:0] idx;
    if (road == ROAD_A) begin
      unique case (ph)
        PH_RED:    idx = IDX_GREEN_A;
        PH_GREEN:  idx = IDX_YELLOW_A;
        PH_YELLOW: idx = IDX_NONE;
        PH_UPDATE: idx = IDX_RED_A;
        default:   idx = IDX_NONE;
      endcase
    end else begin
      unique case (ph)
        PH_RED:    idx = IDX_NONE;
        PH_GREEN:  idx = IDX_YELLOW_B;
        PH_YELLOW: idx = IDX_RED_B;
        PH_UPDATE: idx = IDX_GREEN_B;
        default:   idx = IDX_NONE;
      endcase
    end
    return idx;
  endfunction

  function automatic logic [IDX_W-1:0] road_lamp_idx(road_t road, phase_t ph);
    logic [IDX_W-1:0] idx;
    if (road == ROAD_A) begin
      unique case (ph)
        PH_RED:    idx = IDX_RED_A;
        PH_GREEN:  idx = IDX_GREEN_A;
        PH_YELLOW: idx = IDX_YELLOW_A;
        default:   idx = IDX_RED_A;
      endcase
    end else begin
      unique case (ph)
        PH_RED:    idx = IDX_RED_B;
        PH_GREEN:  idx = IDX_GREEN_B;
        PH_YELLOW: idx = IDX_YELLOW_B;
        default:   idx = IDX_RED_B;
      endcase
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> rtl/core/two_road_traffic_light_sequencer_core.sv
// two-road traffic light sequencer, top level
// in channel: in_valid/in_stall carry second_tick and update_request, one
// transaction per evaluation pass. out channel: out_valid/out_stall carry the
// six lamp bits and both phases after that pass, one result per transaction.
// an accepted transaction lands in the input register; its result is written
// to the result register from there once no stalled result holds it back.
// throughput: one transaction per cycle while the receiver does not stall; the
// phase machines of both roads run in one combinational pass between the input
// register and the result register, which also holds the road state.
// when the receiver stalls, the result register holds, one further
// transaction waits in the input register, and only then is in_stall raised.
// cfg_write/cfg_index/cfg_data write the six staged durations (red, green,
// yellow of road A then road B); indexes past the list are ignored. writes
// belong to idle periods; a commit copies them at the next update phase.
// reset: road A in yellow, road B in red, both timers expired, lamps off,
// staged and active durations 5, 3, 2 per road, no commit pending.
`default_nettype none

module two_road_traffic_light_sequencer_core
  import tlseq_pkg::*;
#(
  parameter int TIME_WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             second_tick,
  input  logic             update_request,
  output logic             out_valid,
  input  logic             out_stall,
  output logic             lamp_red_a,
  output logic             lamp_green_a,
  output logic             lamp_yellow_a,
  output logic             lamp_red_b,
  output logic             lamp_green_b,
  output logic             lamp_yellow_b,
  output logic [1:0]       phase_a,
  output logic [1:0]       phase_b,
  input  logic             cfg_write,
  input  logic [IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0] cfg_data
);

  // input register
  logic in_reg_valid;
  logic tick_reg;
  logic req_reg;
  logic advance;

  // road state, also the result register
  phase_t                             road_a_phase;
  phase_t                             road_b_phase;
  logic [TIME_WIDTH-1:0]              road_a_count;
  logic [TIME_WIDTH-1:0]              road_b_count;
  logic [NUM_DUR-1:0][TIME_WIDTH-1:0] active_dur;
  logic                               update_pending;
  logic [NUM_DUR-1:0]                 lamps_lit;

  logic [NUM_DUR-1:0][CFG_W-1:0]      staged;
  logic [NUM_DUR-1:0][TIME_WIDTH-1:0] staged_m;
  logic [NUM_DUR-1:0][TIME_WIDTH-1:0] reset_dur_m;

  logic [TIME_WIDTH-1:0]              count_a_tick;
  logic [TIME_WIDTH-1:0]              count_b_tick;
  pass_ctl_t                          ctl_start;
  pass_ctl_t                          ctl_mid;
  pass_ctl_t                          ctl_end;
  phase_t                             road_a_phase_next;
  phase_t                             road_b_phase_next;
  logic [TIME_WIDTH-1:0]              road_a_count_next;
  logic [TIME_WIDTH-1:0]              road_b_count_next;
  logic [NUM_DUR-1:0][TIME_WIDTH-1:0] active_mid;
  logic [NUM_DUR-1:0][TIME_WIDTH-1:0] active_dur_next;

  // fit 8-bit durations to the timer width
  always_comb begin
    for (int i = 0; i < NUM_DUR; i++) begin
      staged_m[i]    = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, staged[i]});
      reset_dur_m[i] = TIME_WIDTH'({{TIME_WIDTH{1'b0}}, RESET_DUR[i]});
    end
  end

  assign advance  = in_reg_valid && !(out_valid && out_stall);
  assign in_stall = in_reg_valid && !advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (!in_stall) begin
      in_reg_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      tick_reg <= second_tick;
      req_reg  <= update_request;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      staged <= RESET_DUR;
    end else if (cfg_write && (cfg_index < IDX_W'(NUM_DUR))) begin
      staged[cfg_index] <= cfg_data;
    end
  end

  // one evaluation pass
  assign count_a_tick = (tick_reg && (road_a_count != '0)) ? road_a_count - 1'b1
                                                            : road_a_count;
  assign count_b_tick = (tick_reg && (road_b_count != '0)) ? road_b_count - 1'b1
                                                            : road_b_count;
  assign ctl_start.pending = update_pending | req_reg;
  assign ctl_start.lamps   = lamps_lit;

  tlseq_road #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_road_a (
    .road       (ROAD_A),
    .phase      (road_a_phase),
    .count      (count_a_tick),
    .active     (active_dur),
    .staged     (staged_m),
    .ctl_in     (ctl_start),
    .phase_next (road_a_phase_next),
    .count_next (road_a_count_next),
    .active_next(active_mid),
    .ctl_out    (ctl_mid)
  );

  tlseq_road #(
    .TIME_WIDTH(TIME_WIDTH)
  ) u_road_b (
    .road       (ROAD_B),
    .phase      (road_b_phase),
    .count      (count_b_tick),
    .active     (active_mid),
    .staged     (staged_m),
    .ctl_in     (ctl_mid),
    .phase_next (road_b_phase_next),
    .count_next (road_b_count_next),
    .active_next(active_dur_next),
    .ctl_out    (ctl_end)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid      <= 1'b0;
      road_a_phase   <= PH_YELLOW;
      road_b_phase   <= PH_RED;
      road_a_count   <= '0;
      road_b_count   <= '0;
      active_dur     <= reset_dur_m;
      update_pending <= 1'b0;
      lamps_lit      <= '0;
    end else begin
      if (advance) begin
        out_valid      <= 1'b1;
        road_a_phase   <= road_a_phase_next;
        road_b_phase   <= road_b_phase_next;
        road_a_count   <= road_a_count_next;
        road_b_count   <= road_b_count_next;
        active_dur     <= active_dur_next;
        update_pending <= ctl_end.pending;
        lamps_lit      <= ctl_end.lamps;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign lamp_red_a    = lamps_lit[IDX_RED_A];
  assign lamp_green_a  = lamps_lit[IDX_GREEN_A];
  assign lamp_yellow_a = lamps_lit[IDX_YELLOW_A];
  assign lamp_red_b    = lamps_lit[IDX_RED_B];
  assign lamp_green_b  = lamps_lit[IDX_GREEN_B];
  assign lamp_yellow_b = lamps_lit[IDX_YELLOW_B];
  assign phase_a       = road_a_phase;
  assign phase_b       = road_b_phase;

  // at most one lamp per road is ever lit
  a_one_lamp_per_road: assert property (@(posedge clk) disable iff (rst)
    $onehot0(lamps_lit[2:0]) && $onehot0(lamps_lit[5:3]))
    else $error("more than one lamp lit on a road");

  // a pass through road A's update phase always leaves road A in red with no commit pending
  a_update_a_commits: assert property (@(posedge clk) disable iff (rst)
    advance && (road_a_phase == PH_UPDATE) |=> (road_a_phase == PH_RED) && !update_pending)
    else $error("road A update phase did not commit");

  // a transaction only waits in the input register behind a stalled result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_reg_valid && out_valid && out_stall)
    else $error("input stalled without a stalled result");

endmodule

`default_nettype wire

>>> rtl/core/tlseq_road.sv
// phase machine of one road for a single evaluation pass
`default_nettype none

module tlseq_road
  import tlseq_pkg::*;
#(
  parameter int TIME_WIDTH = 8
) (
  input  road_t                               road,
  input  phase_t                              phase,
  input  logic [TIME_WIDTH-1:0]               count,
  input  logic [NUM_DUR-1:0][TIME_WIDTH-1:0]  active,
  input  logic [NUM_DUR-1:0][TIME_WIDTH-1:0]  staged,
  input  pass_ctl_t                           ctl_in,
  output phase_t                              phase_next,
  output logic [TIME_WIDTH-1:0]               count_next,
  output logic [NUM_DUR-1:0][TIME_WIDTH-1:0]  active_next,
  output pass_ctl_t                           ctl_out
);

  logic [IDX_W-1:0] load_idx;
  logic [IDX_W-1:0] lamp_idx;

  assign load_idx = road_load_idx(road, phase);
  assign lamp_idx = road_lamp_idx(road, phase);

  always_comb begin
    ctl_out     = ctl_in;
    active_next = active;
    count_next  = count;
    phase_next  = phase;
    priority if (phase == PH_UPDATE) begin
      // first road into update takes the pending commit
      if (ctl_in.pending) begin
        ctl_out.pending = 1'b0;
        active_next     = staged;
      end
      if (load_idx != IDX_NONE) begin
        count_next = active_next[load_idx];
      end
      phase_next = road_next_phase(road, phase);
    end else if (count == '0) begin
      if (load_idx != IDX_NONE) begin
        count_next = active[load_idx];
      end
      phase_next    = road_next_phase(road, phase);
      ctl_out.lamps = '0;
    end else begin
      ctl_out.lamps[lamp_idx] = 1'b1;
    end
  end

endmodule

`default_nettype wire
